FILE: hdl/ascon128_aead_engine_core_defines.svh
// assertion helpers for the ascon engine
`ifndef ASCON128_AEAD_ENGINE_CORE_DEFINES_SVH
`define ASCON128_AEAD_ENGINE_CORE_DEFINES_SVH
`define ASC_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);
`define ASC_ASSERT_NEVER(label, expr, msg) \
  `ASC_ASSERT(label, !(expr), msg)
`endif

FILE: hdl/asc_pkg.sv
package asc_pkg;

  localparam logic [63:0] AsconIv = 64'h80400c0600000000;
  localparam int unsigned QueueDepth = 2;

  localparam logic [1:0] CmdStart = 2'd0;
  localparam logic [1:0] CmdAd    = 2'd1;
  localparam logic [1:0] CmdText  = 2'd2;

  typedef struct packed {
    logic [1:0]  cmd;
    logic        decrypt;
    logic [63:0] nonce_hi;
    logic [63:0] nonce_lo;
    logic [63:0] blk;
    logic [3:0]  n;
    logic        last;
    logic [63:0] exp_hi;
    logic [63:0] exp_lo;
  } item_t;

  typedef logic [4:0][63:0] state_t;

  function automatic logic [63:0] ror64(logic [63:0] v, int unsigned r);
    ror64 = (v >> r) | (v << (64 - r));
  endfunction

  function automatic state_t round_fn(state_t s, logic [3:0] i);
    logic [63:0] x0, x1, x2, x3, x4, t0, t1, t2, t3, t4;
    x0 = s[0]; x1 = s[1]; x2 = s[2]; x3 = s[3]; x4 = s[4];
    x2 = x2 ^ {56'd0, 4'hf - i, i};
    x0 = x0 ^ x4;
    x4 = x4 ^ x3;
    x2 = x2 ^ x1;
    t0 = x0 ^ (~x1 & x2);
    t1 = x1 ^ (~x2 & x3);
    t2 = x2 ^ (~x3 & x4);
    t3 = x3 ^ (~x4 & x0);
    t4 = x4 ^ (~x0 & x1);
    t1 = t1 ^ t0;
    t0 = t0 ^ t4;
    t3 = t3 ^ t2;
    t2 = ~t2;
    round_fn[0] = t0 ^ ror64(t0, 19) ^ ror64(t0, 28);
    round_fn[1] = t1 ^ ror64(t1, 61) ^ ror64(t1, 39);
    round_fn[2] = t2 ^ ror64(t2, 1) ^ ror64(t2, 6);
    round_fn[3] = t3 ^ ror64(t3, 10) ^ ror64(t3, 17);
    round_fn[4] = t4 ^ ror64(t4, 7) ^ ror64(t4, 41);
  endfunction

  function automatic logic [63:0] top_mask(logic [3:0] n);
    top_mask = (n == 4'd0) ? 64'd0 : ~(64'hffffffffffffffff >> {n[2:0], 3'b000});
    if (n >= 4'd8) top_mask = '1;
  endfunction

  function automatic logic [63:0] pad_word(logic [3:0] n);
    pad_word = 64'h80 << (7'd56 - {n[2:0], 3'b000});
  endfunction

endpackage

FILE: hdl/asc_front.sv
module asc_front #(
  parameter int unsigned Depth = asc_pkg::QueueDepth
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            valid_i,
  output logic            stall_o,
  input  asc_pkg::item_t  item_i,
  output logic            q_valid_o,
  input  logic            q_pop_i,
  output asc_pkg::item_t  q_item_o
);
  localparam int unsigned Aw = (Depth > 1) ? $clog2(Depth) : 1;
  localparam logic [1:0] CmdNone = 2'd3;
  asc_pkg::item_t mem_q [Depth];
  logic [Aw-1:0] wp_q, wp_d, rp_q, rp_d;
  logic [Aw:0]   cnt_q, cnt_d;
  logic push, pop;
  asc_pkg::item_t cls;

  // classify: normalize count; cmd 3 is dropped at push
  always_comb begin
    cls = item_i;
    if (!item_i.last || item_i.n > 4'd8) cls.n = 4'd8;
    if (!cls.last) cls.n = 4'd8;
  end

  assign stall_o   = (cnt_q == Aw'(0) + (Aw+1)'(Depth));
  assign push      = valid_i && !stall_o && (item_i.cmd != CmdNone);
  assign pop       = q_pop_i && (cnt_q != '0);
  assign q_valid_o = (cnt_q != '0);
  assign q_item_o  = mem_q[rp_q];

  always_comb begin
    wp_d = wp_q; rp_d = rp_q; cnt_d = cnt_q;
    if (push) wp_d = (wp_q == Aw'(Depth-1)) ? '0 : wp_q + 1'b1;
    if (pop)  rp_d = (rp_q == Aw'(Depth-1)) ? '0 : rp_q + 1'b1;
    cnt_d = cnt_q + (Aw+1)'(push) - (Aw+1)'(pop);
  end

  always_ff @(posedge clk_i) begin
    if (push) mem_q[wp_q] <= cls;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q <= '0; rp_q <= '0; cnt_q <= '0;
    end else begin
      wp_q <= wp_d; rp_q <= rp_d; cnt_q <= cnt_d;
    end
  end
endmodule

FILE: hdl/asc_back.sv
module asc_back (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic [63:0]     key_hi_i,
  input  logic [63:0]     key_lo_i,
  input  logic            q_valid_i,
  output logic            q_pop_o,
  input  asc_pkg::item_t  q_item_i,
  output logic            res_valid_o,
  input  logic            res_stall_i,
  output logic [63:0]     out_block_o,
  output logic [3:0]      out_count_o,
  output logic [63:0]     tag_hi_o,
  output logic [63:0]     tag_lo_o,
  output logic            tag_match_o,
  output logic            is_final_o
);
  typedef enum logic [3:0] {
    StIdle  = 4'b0001,
    StPerm  = 4'b0010,
    StPad   = 4'b0100,
    StFinal = 4'b1000
  } st_e;

  // what follows the last round of a permutation
  typedef enum logic [1:0] {
    TailNone    = 2'd0,
    TailAdPad   = 2'd1,
    TailFinal   = 2'd2,
    TailTextPad = 2'd3
  } tail_e;

  st_e st_q, st_d;
  asc_pkg::state_t s_q, s_d;
  logic [3:0] rnd_q, rnd_d;
  logic started_q, started_d, dec_q, dec_d;
  asc_pkg::item_t it_q, it_d;
  tail_e tail_q, tail_d;
  logic rv_q, rv_d;
  logic [63:0] ob_q, ob_d, th_q, th_d, tl_q, tl_d;
  logic [3:0] oc_q, oc_d;
  logic tm_q, tm_d, fin_q, fin_d;
  logic out_free;
  logic [63:0] m, o;

  assign out_free = !rv_q || !res_stall_i;
  assign q_pop_o  = (st_q == StIdle) && q_valid_i && out_free;

  always_comb begin
    st_d = st_q; s_d = s_q; rnd_d = rnd_q; started_d = started_q; dec_d = dec_q;
    it_d = it_q; tail_d = tail_q; rv_d = rv_q && res_stall_i;
    ob_d = ob_q; oc_d = oc_q; th_d = th_q; tl_d = tl_q; tm_d = tm_q; fin_d = fin_q;
    m = asc_pkg::top_mask(q_item_i.n);
    o = '0;
    case (st_q)
      StIdle: begin
        if (q_pop_o) begin
          it_d = q_item_i;
          tail_d = TailNone;
          if (q_item_i.cmd == asc_pkg::CmdStart) begin
            s_d = {q_item_i.nonce_lo, q_item_i.nonce_hi, key_lo_i, key_hi_i, asc_pkg::AsconIv};
            dec_d = q_item_i.decrypt;
            started_d = 1'b0;
            rnd_d = 4'd0; tail_d = TailFinal; st_d = StPerm;
          end else if (q_item_i.cmd == asc_pkg::CmdAd) begin
            if (!started_q) begin
              if (q_item_i.n == 4'd8) begin
                s_d[0] = s_q[0] ^ q_item_i.blk;
                if (q_item_i.last) tail_d = TailAdPad;
              end else begin
                s_d[0] = s_q[0] ^ (q_item_i.blk & m) ^ asc_pkg::pad_word(q_item_i.n);
              end
              rnd_d = 4'd6; st_d = StPerm;
            end
          end else begin
            if (!started_q) s_d[4] = s_q[4] ^ 64'd1;
            started_d = 1'b1;
            if (q_item_i.n == 4'd8) begin
              o = s_q[0] ^ q_item_i.blk;
              s_d[0] = dec_q ? q_item_i.blk : o;
            end else begin
              o = (s_q[0] ^ q_item_i.blk) & m;
              s_d[0] = (dec_q ? ((s_q[0] & ~m) | (q_item_i.blk & m))
                              : (s_q[0] ^ (q_item_i.blk & m))) ^ asc_pkg::pad_word(q_item_i.n);
            end
            ob_d = o; oc_d = q_item_i.n; th_d = '0; tl_d = '0; tm_d = 1'b0; fin_d = 1'b0;
            if (q_item_i.last) begin
              if (q_item_i.n == 4'd8) begin
                // full last block: 6 rounds, then pad and key mix
                rnd_d = 4'd6; tail_d = TailTextPad; st_d = StPerm;
              end else begin
                s_d[1] = s_q[1] ^ key_hi_i;
                s_d[2] = s_q[2] ^ key_lo_i;
                rnd_d = 4'd0; tail_d = TailFinal; st_d = StPerm;
              end
            end else begin
              rv_d = 1'b1;
              rnd_d = 4'd6; st_d = StPerm;
            end
          end
        end
      end
      StPerm: begin
        s_d = asc_pkg::round_fn(s_q, rnd_q);
        rnd_d = rnd_q + 4'd1;
        if (rnd_q == 4'd11) begin
          if (tail_q == TailAdPad) begin
            s_d[0] = s_d[0] ^ asc_pkg::pad_word(4'd0);
            tail_d = TailNone; rnd_d = 4'd6;
          end else if (tail_q == TailTextPad) begin
            s_d[0] = s_d[0] ^ asc_pkg::pad_word(4'd0);
            s_d[1] = s_d[1] ^ key_hi_i;
            s_d[2] = s_d[2] ^ key_lo_i;
            tail_d = TailFinal; rnd_d = 4'd0;
          end else if (tail_q == TailFinal) begin
            st_d = StFinal;
          end else begin
            st_d = StIdle;
          end
        end
      end
      StFinal: begin
        // key mix after 12 rounds; text final also emits tag
        s_d[3] = s_q[3] ^ key_hi_i;
        s_d[4] = s_q[4] ^ key_lo_i;
        if (it_q.cmd == asc_pkg::CmdStart) begin
          st_d = StIdle;
        end else if (out_free) begin
          rv_d = 1'b1; th_d = s_d[3]; tl_d = s_d[4]; fin_d = 1'b1;
          tm_d = dec_q && (s_d[3] == it_q.exp_hi) && (s_d[4] == it_q.exp_lo);
          st_d = StIdle;
        end else begin
          s_d = s_q;
        end
      end
      default: st_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i) begin
    it_q <= it_d; ob_q <= ob_d; oc_q <= oc_d; th_q <= th_d; tl_q <= tl_d;
    rnd_q <= rnd_d; tail_q <= tail_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= StIdle; s_q <= '0; started_q <= 1'b0; dec_q <= 1'b0; rv_q <= 1'b0;
      tm_q <= 1'b0; fin_q <= 1'b0;
    end else begin
      st_q <= st_d; s_q <= s_d; started_q <= started_d; dec_q <= dec_d; rv_q <= rv_d;
      tm_q <= tm_d; fin_q <= fin_d;
    end
  end

  assign res_valid_o = rv_q;
  assign out_block_o = ob_q;
  assign out_count_o = oc_q;
  assign tag_hi_o    = th_q;
  assign tag_lo_o    = tl_q;
  assign tag_match_o = tm_q;
  assign is_final_o  = fin_q;
endmodule

FILE: hdl/ascon128_aead_engine_core.sv
// ascon-128 aead engine: one 64-bit block per transaction, one permutation round per cycle
// associated data / text block: load plus 6 rounds; full last ad block: 6 rounds, pad, 6 more
// start: load, 12 rounds, key mix; last text block: load, 12 rounds, key mix to tag result,
// with 6 extra rounds before finalization when the last text block is full
// non-last text result registered in the cycle after its block leaves the 2-entry queue
// reset (async, active low) clears keys, permutation state, mode and queue
`include "ascon128_aead_engine_core_defines.svh"
module ascon128_aead_engine_core #(
  parameter int unsigned QueueDepth = asc_pkg::QueueDepth
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic        cfg_index_i,
  input  logic [63:0] cfg_data_i,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [1:0]  cmd_i,
  input  logic        decrypt_i,
  input  logic [63:0] nonce_hi_i,
  input  logic [63:0] nonce_lo_i,
  input  logic [63:0] block_i,
  input  logic [3:0]  byte_count_i,
  input  logic        last_i,
  input  logic [63:0] expect_tag_hi_i,
  input  logic [63:0] expect_tag_lo_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [63:0] out_block_o,
  output logic [3:0]  out_count_o,
  output logic [63:0] tag_hi_o,
  output logic [63:0] tag_lo_o,
  output logic        tag_match_o,
  output logic        is_final_o
);
  logic [63:0] key_hi_q, key_lo_q;
  asc_pkg::item_t item, q_item;
  logic q_valid, q_pop;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_hi_q <= '0; key_lo_q <= '0;
    end else if (cfg_we_i) begin
      if (cfg_index_i) key_lo_q <= cfg_data_i;
      else key_hi_q <= cfg_data_i;
    end
  end

  assign item = '{cmd: cmd_i, decrypt: decrypt_i, nonce_hi: nonce_hi_i,
                  nonce_lo: nonce_lo_i, blk: block_i, n: byte_count_i, last: last_i,
                  exp_hi: expect_tag_hi_i, exp_lo: expect_tag_lo_i};

  asc_front #(.Depth(QueueDepth)) u_front (
    .clk_i, .rst_ni, .valid_i(in_valid_i), .stall_o(in_stall_o), .item_i(item),
    .q_valid_o(q_valid), .q_pop_i(q_pop), .q_item_o(q_item)
  );

  asc_back u_back (
    .clk_i, .rst_ni, .key_hi_i(key_hi_q), .key_lo_i(key_lo_q),
    .q_valid_i(q_valid), .q_pop_o(q_pop), .q_item_i(q_item),
    .res_valid_o(out_valid_o), .res_stall_i(out_stall_i),
    .out_block_o, .out_count_o, .tag_hi_o, .tag_lo_o, .tag_match_o, .is_final_o
  );

  `ASC_ASSERT(a_pop_needs_item, q_pop |-> q_valid, "pop from empty queue")
  `ASC_ASSERT_NEVER(a_tag_without_final, tag_match_o && !is_final_o, "tag match off final")
  `ASC_ASSERT(a_count_range, out_valid_o |-> out_count_o <= 4'd8, "out count range")
endmodule

FILE: sim/ascon128_aead_engine_core_tb.sv
module ascon128_aead_engine_core_tb;
  import asc_pkg::*;

  localparam logic RegKeyHi = 1'b0;
  localparam logic RegKeyLo = 1'b1;
  localparam logic [1:0] CmdNone = 2'd3;
  localparam int unsigned CycleLimit = 400000;
  localparam int unsigned HoldCycles = 300;
  localparam int unsigned DrainCycles = 80;

  typedef struct packed {
    logic [4:0][63:0] x;
    logic             text_on;
    logic             dec;
  } sponge_t;

  typedef struct packed {
    logic [63:0] blk;
    logic [3:0]  cnt;
    logic [63:0] th;
    logic [63:0] tl;
    logic        match;
    logic        fin;
  } text_out_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_we_i = 1'b0;
  logic        cfg_index_i = 1'b0;
  logic [63:0] cfg_data_i = '0;
  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  logic [1:0]  cmd_i = CmdStart;
  logic        decrypt_i = 1'b0;
  logic [63:0] nonce_hi_i = '0;
  logic [63:0] nonce_lo_i = '0;
  logic [63:0] block_i = '0;
  logic [3:0]  byte_count_i = '0;
  logic        last_i = 1'b0;
  logic [63:0] expect_tag_hi_i = '0;
  logic [63:0] expect_tag_lo_i = '0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  logic [63:0] out_block_o;
  logic [3:0]  out_count_o;
  logic [63:0] tag_hi_o;
  logic [63:0] tag_lo_o;
  logic        tag_match_o;
  logic        is_final_o;

  ascon128_aead_engine_core uut (.*);

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  logic [63:0] key_hi, key_lo;
  sponge_t     live;
  item_t       feed_q[$];
  text_out_t   want_q[$];
  int unsigned mismatches = 0, texts_checked = 0, finals_seen = 0, matches_seen = 0;
  int unsigned items_sent = 0, cycles = 0;
  bit          calm = 1'b0, hold_req = 1'b0;

  function automatic logic [63:0] rotr(logic [63:0] v, int unsigned r);
    return (v >> r) | (v << (64 - r));
  endfunction

  function automatic logic [4:0][63:0] rounds(logic [4:0][63:0] s, int unsigned nr);
    logic [63:0] a0, a1, a2, a3, a4, b0, b1, b2, b3, b4;
    for (int unsigned i = 12 - nr; i < 12; i++) begin
      a0 = s[0]; a1 = s[1]; a2 = s[2]; a3 = s[3]; a4 = s[4];
      a2 ^= 64'(((15 - i) << 4) | i);
      a0 ^= a4; a4 ^= a3; a2 ^= a1;
      b0 = a0 ^ (~a1 & a2);
      b1 = a1 ^ (~a2 & a3);
      b2 = a2 ^ (~a3 & a4);
      b3 = a3 ^ (~a4 & a0);
      b4 = a4 ^ (~a0 & a1);
      b1 ^= b0; b0 ^= b4; b3 ^= b2; b2 = ~b2;
      s[0] = b0 ^ rotr(b0, 19) ^ rotr(b0, 28);
      s[1] = b1 ^ rotr(b1, 61) ^ rotr(b1, 39);
      s[2] = b2 ^ rotr(b2, 1) ^ rotr(b2, 6);
      s[3] = b3 ^ rotr(b3, 10) ^ rotr(b3, 17);
      s[4] = b4 ^ rotr(b4, 7) ^ rotr(b4, 41);
    end
    return s;
  endfunction

  function automatic logic [63:0] keep_bytes(int unsigned n);
    if (n == 0) return '0;
    if (n >= 8) return '1;
    return ~(64'hffff_ffff_ffff_ffff >> (8 * n));
  endfunction

  function automatic logic [63:0] pad_at(int unsigned n);
    return 64'h80 << (56 - 8 * n);
  endfunction

  // advances the sponge by one transaction, returns 1 when a text result comes out
  function automatic bit absorb_item(inout sponge_t m, input item_t it,
                                     input logic [63:0] kh, kl, output text_out_t r);
    int unsigned n;
    logic [63:0] msk, o;
    r = '0;
    n = (it.n > 8) ? 8 : it.n;
    if (!it.last) n = 8;
    case (it.cmd)
      CmdStart: begin
        m.x[0] = AsconIv; m.x[1] = kh; m.x[2] = kl;
        m.x[3] = it.nonce_hi; m.x[4] = it.nonce_lo;
        m.x = rounds(m.x, 12);
        m.x[3] ^= kh; m.x[4] ^= kl;
        m.dec = it.decrypt;
        m.text_on = 1'b0;
        return 1'b0;
      end
      CmdAd: begin
        if (m.text_on) return 1'b0;
        if (n == 8) begin
          m.x[0] ^= it.blk;
          m.x = rounds(m.x, 6);
          if (it.last) begin
            m.x[0] ^= pad_at(0);
            m.x = rounds(m.x, 6);
          end
        end else begin
          m.x[0] ^= (it.blk & keep_bytes(n)) ^ pad_at(n);
          m.x = rounds(m.x, 6);
        end
        return 1'b0;
      end
      CmdText: begin
        if (!m.text_on) begin
          m.x[4] ^= 64'd1;
          m.text_on = 1'b1;
        end
        if (n == 8) begin
          if (m.dec) begin
            o = m.x[0] ^ it.blk;
            m.x[0] = it.blk;
          end else begin
            m.x[0] ^= it.blk;
            o = m.x[0];
          end
          m.x = rounds(m.x, 6);
          if (it.last) m.x[0] ^= pad_at(0);
        end else begin
          msk = keep_bytes(n);
          if (m.dec) begin
            o = (m.x[0] ^ it.blk) & msk;
            m.x[0] = (m.x[0] & ~msk) | (it.blk & msk);
          end else begin
            m.x[0] ^= it.blk & msk;
            o = m.x[0] & msk;
          end
          m.x[0] ^= pad_at(n);
        end
        r.blk = o;
        r.cnt = 4'(n);
        if (it.last) begin
          m.x[1] ^= kh; m.x[2] ^= kl;
          m.x = rounds(m.x, 12);
          m.x[3] ^= kh; m.x[4] ^= kl;
          r.th = m.x[3];
          r.tl = m.x[4];
          r.match = m.dec && m.x[3] == it.exp_hi && m.x[4] == it.exp_lo;
          r.fin = 1'b1;
        end
        return 1'b1;
      end
      default: return 1'b0;
    endcase
  endfunction

  function automatic item_t rand_item(logic [1:0] cmd);
    item_t it;
    it.cmd = cmd;
    it.decrypt = 1'($urandom_range(1, 0));
    it.nonce_hi = {$urandom, $urandom};
    it.nonce_lo = {$urandom, $urandom};
    it.blk = {$urandom, $urandom};
    it.n = 4'($urandom_range(15, 0));
    it.last = 1'b0;
    it.exp_hi = {$urandom, $urandom};
    it.exp_lo = {$urandom, $urandom};
    return it;
  endfunction

  // well-formed message; in decrypt mode the ciphertext and tag come from an encrypt pass
  task automatic queue_message(bit dec, int unsigned n_ad, int unsigned n_txt);
    item_t     msg[$];
    item_t     it;
    sponge_t   scratch;
    text_out_t r;
    scratch = '0;
    it = rand_item(CmdStart);
    it.decrypt = 1'b0;
    msg.push_back(it);
    for (int unsigned i = 0; i < n_ad; i++) begin
      it = rand_item(CmdAd);
      it.last = (i == n_ad - 1);
      if (it.last && $urandom_range(3, 0) != 0) it.n = 4'($urandom_range(8, 0));
      msg.push_back(it);
    end
    for (int unsigned i = 0; i < n_txt; i++) begin
      it = rand_item(CmdText);
      it.last = (i == n_txt - 1);
      if (it.last && $urandom_range(3, 0) != 0) it.n = 4'($urandom_range(8, 0));
      msg.push_back(it);
    end
    if (dec) begin
      foreach (msg[i]) begin
        if (absorb_item(scratch, msg[i], key_hi, key_lo, r)) begin
          msg[i].blk = r.blk | (msg[i].blk & ~keep_bytes(r.cnt));
          if (r.fin) begin
            msg[i].exp_hi = r.th;
            msg[i].exp_lo = r.tl;
            // corrupt the tag now and then
            if ($urandom_range(3, 0) == 0) msg[i].exp_lo[$urandom_range(63, 0)] ^= 1'b1;
          end
        end
      end
      msg[0].decrypt = 1'b1;
    end
    foreach (msg[i]) feed_q.push_back(msg[i]);
  endtask

  task automatic write_key(logic idx, logic [63:0] val);
    @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= val;
    if (idx == RegKeyHi) key_hi = val;
    else key_lo = val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic wait_idle();
    while (feed_q.size() != 0 || in_valid_i || want_q.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  task automatic random_phase(int unsigned n_items);
    int unsigned start_sz;
    item_t it;
    start_sz = feed_q.size();
    while (feed_q.size() - start_sz < n_items) begin
      if ($urandom_range(9, 0) == 0) begin
        it = rand_item(2'($urandom_range(3, 0)));
        it.last = 1'($urandom_range(1, 0));
        feed_q.push_back(it);
      end else begin
        queue_message(1'($urandom_range(1, 0)), $urandom_range(3, 0), $urandom_range(4, 1));
      end
    end
  endtask

  // driver
  int unsigned in_gap = 0;
  always @(posedge clk_i) begin
    text_out_t r;
    item_t     cur;
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o) begin
        cur = '{cmd: cmd_i, decrypt: decrypt_i, nonce_hi: nonce_hi_i, nonce_lo: nonce_lo_i,
                blk: block_i, n: byte_count_i, last: last_i,
                exp_hi: expect_tag_hi_i, exp_lo: expect_tag_lo_i};
        items_sent++;
        if (absorb_item(live, cur, key_hi, key_lo, r)) want_q.push_back(r);
      end
      if (!in_valid_i || !in_stall_o) begin
        if (in_gap != 0) begin
          in_gap--;
          in_valid_i <= 1'b0;
        end else if (!calm && $urandom_range(7, 0) == 0) begin
          in_gap = $urandom_range(4, 0);
          in_valid_i <= 1'b0;
        end else if (feed_q.size() != 0) begin
          cur = feed_q.pop_front();
          in_valid_i <= 1'b1;
          cmd_i <= cur.cmd;
          decrypt_i <= cur.decrypt;
          nonce_hi_i <= cur.nonce_hi;
          nonce_lo_i <= cur.nonce_lo;
          block_i <= cur.blk;
          byte_count_i <= cur.n;
          last_i <= cur.last;
          expect_tag_hi_i <= cur.exp_hi;
          expect_tag_lo_i <= cur.exp_lo;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // monitor
  int unsigned out_gap = 0, hold_left = 0;
  always @(posedge clk_i) begin
    text_out_t want;
    if (rst_ni) begin
      cycles++;
      if (cycles > CycleLimit) begin
        $display("timeout after %0d cycles, %0d results outstanding", cycles, want_q.size());
        $display("** ascon128_aead_engine_core: FAILED **");
        $finish;
      end
      if (out_valid_o && !out_stall_i) begin
        if (want_q.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected result block %h", out_block_o);
        end else begin
          want = want_q.pop_front();
          texts_checked++;
          if (is_final_o) finals_seen++;
          if (tag_match_o) matches_seen++;
          if (out_block_o !== want.blk || out_count_o !== want.cnt || tag_hi_o !== want.th ||
              tag_lo_o !== want.tl || tag_match_o !== want.match || is_final_o !== want.fin) begin
            mismatches++;
            if (mismatches <= 10) begin
              $display("mismatch exp blk %h cnt %0d tag %h%h m %b f %b", want.blk, want.cnt,
                       want.th, want.tl, want.match, want.fin);
              $display("         got blk %h cnt %0d tag %h%h m %b f %b", out_block_o,
                       out_count_o, tag_hi_o, tag_lo_o, tag_match_o, is_final_o);
            end
          end
        end
      end
      if (hold_req && hold_left == 0) begin
        hold_req = 1'b0;
        hold_left = HoldCycles;
      end
      if (hold_left != 0) begin
        hold_left--;
        out_stall_i <= 1'b1;
      end else if (out_gap != 0) begin
        out_gap--;
        out_stall_i <= 1'b1;
      end else if (!calm && $urandom_range(5, 0) == 0) begin
        out_gap = $urandom_range(4, 0);
        out_stall_i <= 1'b1;
      end else begin
        out_stall_i <= 1'b0;
      end
    end
  end

  initial begin
    item_t it;
    live = '0;
    key_hi = '0;
    key_lo = '0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    // text before any start, then the corner cases on the zero key
    it = rand_item(CmdText); it.n = 4'd15; feed_q.push_back(it);
    it = rand_item(CmdText); it.last = 1'b1; it.n = 4'd3; feed_q.push_back(it);
    it = rand_item(CmdStart); it.nonce_hi = '1; it.nonce_lo = '1; it.decrypt = 1'b0;
    feed_q.push_back(it);
    it = rand_item(CmdAd); it.last = 1'b1; it.n = 4'd0; it.blk = '1; feed_q.push_back(it);
    it = rand_item(CmdText); it.blk = '0; it.n = 4'd2; feed_q.push_back(it);
    it = rand_item(CmdAd); it.last = 1'b1; feed_q.push_back(it);
    it = rand_item(CmdNone); it.last = 1'b1; feed_q.push_back(it);
    it = rand_item(CmdText); it.last = 1'b1; it.n = 4'd8; it.blk = '1; feed_q.push_back(it);
    it = rand_item(CmdText); it.last = 1'b1; it.n = 4'd12; feed_q.push_back(it);
    it = rand_item(CmdStart); it.nonce_hi = '0; it.nonce_lo = '0; it.decrypt = 1'b1;
    feed_q.push_back(it);
    it = rand_item(CmdAd); it.last = 1'b1; it.n = 4'd8; feed_q.push_back(it);
    it = rand_item(CmdAd); it.last = 1'b1; it.n = 4'd0; feed_q.push_back(it);
    it = rand_item(CmdText); it.last = 1'b1; it.n = 4'd0; feed_q.push_back(it);
    it = rand_item(CmdText); it.last = 1'b1; it.n = 4'd7; feed_q.push_back(it);
    queue_message(1'b1, 1, 2);
    queue_message(1'b0, 0, 1);
    wait_idle();

    write_key(RegKeyHi, '1);
    write_key(RegKeyLo, '1);
    random_phase(200);
    wait_idle();

    write_key(RegKeyHi, {$urandom, $urandom});
    write_key(RegKeyLo, {$urandom, $urandom});
    random_phase(100);
    hold_req = 1'b1;
    random_phase(110);
    wait_idle();

    write_key(RegKeyHi, {$urandom, $urandom});
    write_key(RegKeyLo, '0);
    random_phase(200);
    wait_idle();

    write_key(RegKeyHi, {$urandom, $urandom});
    write_key(RegKeyLo, {$urandom, $urandom});
    random_phase(200);
    while (feed_q.size() > 60) @(posedge clk_i);
    calm = 1'b1;
    wait_idle();

    $display("%0d transactions in, %0d text results checked (%0d with tag, %0d tag matches)",
             items_sent, texts_checked, finals_seen, matches_seen);
    $display("five key settings incl. all-zero and all-one, long output hold, %0d mismatches",
             mismatches);
    if (mismatches == 0 && want_q.size() == 0) begin
      $display("** ascon128_aead_engine_core: PASSED **");
    end else begin
      $display("** ascon128_aead_engine_core: FAILED **");
    end
    $finish;
  end

endmodule
